// ----- hw/rtl/clcd_pkg.sv -----
`timescale 1ns / 1ps

package clcd_pkg;

    typedef logic [2:0]  opcode_t;
    typedef logic [7:0]  lcd_byte_t;
    typedef logic [15:0] tick_count_t;
    typedef logic [2:0]  cfg_index_t;

    localparam opcode_t OP_TICK   = 3'd0;
    localparam opcode_t OP_CMD    = 3'd1;
    localparam opcode_t OP_DATA   = 3'd2;
    localparam opcode_t OP_CURSOR = 3'd3;
    localparam opcode_t OP_CLEAR  = 3'd4;

    localparam cfg_index_t CFG_NIBBLE_UPPER = 3'd0;
    localparam cfg_index_t CFG_POWER_WAIT   = 3'd1;
    localparam cfg_index_t CFG_ENABLE_WAIT  = 3'd2;
    localparam cfg_index_t CFG_CMD_WAIT     = 3'd3;
    localparam cfg_index_t CFG_CLEAR_WAIT   = 3'd4;

    localparam tick_count_t POWER_WAIT_RST  = 16'd50000;
    localparam tick_count_t ENABLE_WAIT_RST = 16'd1000;
    localparam tick_count_t CMD_WAIT_RST    = 16'd39;
    localparam tick_count_t CLEAR_WAIT_RST  = 16'd1530;

    localparam logic [2:0] INIT_COUNT = 3'd5;
    localparam lcd_byte_t  LCD_CLEAR  = 8'h01;
    localparam lcd_byte_t  DDRAM_SET  = 8'h80;

    function automatic lcd_byte_t init_byte(input logic [2:0] step);
        lcd_byte_t b;
        unique case (step)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] b;
        unique case (row)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h10;
            default: b = 7'h50;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/clcd_req_if.sv -----
`timescale 1ns / 1ps

interface clcd_req_if
    import clcd_pkg::*;
();
    logic      valid;
    logic      ready;
    opcode_t   opcode;
    lcd_byte_t byte_value;
    logic [1:0] row;
    logic [5:0] column;

    modport source (output valid, output opcode, output byte_value, output row,
                    output column, input ready);
    modport sink   (input valid, input opcode, input byte_value, input row,
                    input column, output ready);
endinterface

// ----- hw/rtl/clcd_res_if.sv -----
`timescale 1ns / 1ps

interface clcd_res_if
    import clcd_pkg::*;
();
    logic      valid;
    logic      ready;
    lcd_byte_t data_pins;
    logic      select_data;
    logic      read_not_write;
    logic      enable;
    logic      busy_res;
    logic      init_done;
    logic      accepted;

    modport source (output valid, output data_pins, output select_data,
                    output read_not_write, output enable, output busy_res,
                    output init_done, output accepted, input ready);
    modport sink   (input valid, input data_pins, input select_data,
                    input read_not_write, input enable, input busy_res,
                    input init_done, input accepted, output ready);
endinterface

// ----- hw/rtl/char_lcd_nibble_sequencer_core.sv -----
`timescale 1ns / 1ps

// Four-bit character LCD sequencer. Each item on req is one clock tick of the
// LCD timing: opcode 0 just advances the sequencer, opcodes 1..4 (command byte,
// data byte, set cursor, clear) are requests that are taken only when the
// panel is idle and the power-on init (0x02, 0x28, 0x0C, 0x06, clear) has
// finished; a refused request still advances the sequencer. Every item gives
// exactly one result on res with the pin levels after that tick and whether
// the request was taken. One item is accepted per clock; its result appears in
// the output register on the next clock; req stalls only while it is full and
// res is not ready. All delays are counted in items, from the configuration
// registers; the user must write them only while idle, unchecked by the core.
module char_lcd_nibble_sequencer_core
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  cfg_index_t  cfg_index,
    input  tick_count_t cfg_data,
    clcd_req_if.sink    req,
    clcd_res_if.source  res
);

    localparam logic [2:0] PH_POWER = 3'd0;
    localparam logic [2:0] PH_HIGH  = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_LOW   = 3'd3;
    localparam logic [2:0] PH_POST  = 3'd4;
    localparam logic [2:0] PH_IDLE  = 3'd5;

    logic        nibble_upper_reg;
    tick_count_t power_wait_reg;
    tick_count_t enable_wait_reg;
    tick_count_t cmd_wait_reg;
    tick_count_t clear_wait_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  init_step_reg, init_step_next;
    tick_count_t wait_count_reg, wait_count_next;
    lcd_byte_t   pending_byte_reg, pending_byte_next;
    logic        pending_select_reg, pending_select_next;
    tick_count_t pending_after_reg, pending_after_next;
    logic        init_finished_reg, init_finished_next;

    logic        res_valid_reg;
    lcd_byte_t   data_pins_reg, data_pins_next;
    logic        select_data_reg;
    logic        enable_reg, enable_next;
    logic        busy_reg, busy_next;
    logic        init_done_reg;
    logic        accepted_reg, accepted_next;

    logic        req_take;
    logic        is_request;
    logic        start;
    lcd_byte_t   start_byte;
    logic        start_select;
    tick_count_t start_after;
    logic [2:0]  step_inc;
    logic [6:0]  cursor_addr;
    logic [3:0]  nibble;

    assign req.ready = !res_valid_reg || res.ready;
    assign req_take  = req.valid && req.ready;

    assign is_request = (req.opcode == OP_CMD) || (req.opcode == OP_DATA) ||
                        (req.opcode == OP_CURSOR) || (req.opcode == OP_CLEAR);
    assign cursor_addr = row_base(req.row) + {1'b0, req.column};
    assign step_inc    = init_step_reg + 3'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        init_step_next      = init_step_reg;
        wait_count_next     = wait_count_reg;
        init_finished_next  = init_finished_reg;
        accepted_next       = 1'b0;
        start               = 1'b0;
        start_byte          = pending_byte_reg;
        start_select        = 1'b0;
        start_after         = cmd_wait_reg;

        if (is_request && phase_reg == PH_IDLE && init_finished_reg)
        begin
            accepted_next = 1'b1;
            start         = 1'b1;
            unique case (req.opcode)
                OP_CMD:    start_byte = req.byte_value;
                OP_DATA:
                begin
                    start_byte   = req.byte_value;
                    start_select = 1'b1;
                end
                OP_CURSOR: start_byte = DDRAM_SET | {1'b0, cursor_addr};
                default:
                begin
                    start_byte  = LCD_CLEAR;
                    start_after = clear_wait_reg;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_POWER:
                begin
                    if (wait_count_reg >= power_wait_reg)
                    begin
                        init_step_next = 3'd0;
                        start          = 1'b1;
                        start_byte     = init_byte(3'd0);
                    end
                    else
                        wait_count_next = wait_count_reg + 16'd1;
                end
                PH_HIGH:
                begin
                    if (wait_count_reg >= enable_wait_reg)
                    begin
                        phase_next      = PH_GAP;
                        wait_count_next = '0;
                    end
                    else
                        wait_count_next = wait_count_reg + 16'd1;
                end
                PH_GAP:
                begin
                    phase_next      = PH_LOW;
                    wait_count_next = '0;
                end
                PH_LOW:
                begin
                    if (wait_count_reg >= enable_wait_reg)
                    begin
                        phase_next      = PH_POST;
                        wait_count_next = '0;
                    end
                    else
                        wait_count_next = wait_count_reg + 16'd1;
                end
                PH_POST:
                begin
                    if (wait_count_reg >= pending_after_reg)
                    begin
                        phase_next      = PH_IDLE;
                        wait_count_next = '0;
                        if (!init_finished_reg)
                        begin
                            init_step_next = step_inc;
                            if (step_inc < INIT_COUNT)
                            begin
                                start      = 1'b1;
                                start_byte = init_byte(step_inc);
                                // last init byte is clear and needs the long wait
                                if (step_inc == INIT_COUNT - 3'd1)
                                    start_after = clear_wait_reg;
                            end
                            else
                                init_finished_next = 1'b1;
                        end
                    end
                    else
                        wait_count_next = wait_count_reg + 16'd1;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        pending_byte_next   = pending_byte_reg;
        pending_select_next = pending_select_reg;
        pending_after_next  = pending_after_reg;
        if (start)
        begin
            pending_byte_next   = start_byte;
            pending_select_next = start_select;
            pending_after_next  = start_after;
            wait_count_next     = '0;
            phase_next          = PH_HIGH;
        end

        if (phase_next == PH_HIGH || phase_next == PH_GAP)
            nibble = pending_byte_next[7:4];
        else if (phase_next == PH_LOW)
            nibble = pending_byte_next[3:0];
        else
            nibble = 4'h0;

        data_pins_next = nibble_upper_reg ? {nibble, 4'h0} : {4'h0, nibble};
        enable_next    = (phase_next == PH_HIGH) || (phase_next == PH_LOW);
        busy_next      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_upper_reg <= 1'b1;
            power_wait_reg   <= POWER_WAIT_RST;
            enable_wait_reg  <= ENABLE_WAIT_RST;
            cmd_wait_reg     <= CMD_WAIT_RST;
            clear_wait_reg   <= CLEAR_WAIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_NIBBLE_UPPER: nibble_upper_reg <= cfg_data[0];
                CFG_POWER_WAIT:   power_wait_reg   <= cfg_data;
                CFG_ENABLE_WAIT:  enable_wait_reg  <= cfg_data;
                CFG_CMD_WAIT:     cmd_wait_reg     <= cfg_data;
                CFG_CLEAR_WAIT:   clear_wait_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_POWER;
            init_step_reg      <= '0;
            wait_count_reg     <= '0;
            pending_byte_reg   <= '0;
            pending_select_reg <= 1'b0;
            pending_after_reg  <= '0;
            init_finished_reg  <= 1'b0;
        end
        else if (req_take)
        begin
            phase_reg          <= phase_next;
            init_step_reg      <= init_step_next;
            wait_count_reg     <= wait_count_next;
            pending_byte_reg   <= pending_byte_next;
            pending_select_reg <= pending_select_next;
            pending_after_reg  <= pending_after_next;
            init_finished_reg  <= init_finished_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (req_take)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            data_pins_reg   <= data_pins_next;
            select_data_reg <= pending_select_next;
            enable_reg      <= enable_next;
            busy_reg        <= busy_next;
            init_done_reg   <= init_finished_next;
            accepted_reg    <= accepted_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.data_pins      = data_pins_reg;
    assign res.select_data    = select_data_reg;
    assign res.read_not_write = 1'b0;
    assign res.enable         = enable_reg;
    assign res.busy_res       = busy_reg;
    assign res.init_done      = init_done_reg;
    assign res.accepted       = accepted_reg;

endmodule

// ----- hw/rtl/clcd_checker.sv -----
`timescale 1ns / 1ps

module clcd_checker
    import clcd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      res_valid,
    input logic      res_ready,
    input lcd_byte_t data_pins,
    input logic      enable,
    input logic      busy_res,
    input logic      init_done,
    input logic      accepted
);

    // E only pulses inside a send
    a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && enable |-> busy_res)
        else $error("enable high while not busy");

    // a taken request starts its send at once, and only after init
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && accepted |-> enable && busy_res && init_done)
        else $error("accepted request did not start a send");

    // idle bus is quiet
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> !enable && data_pins == 8'h00)
        else $error("pins driven while idle");

    // init_done never drops between consecutive results
    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && init_done ##1 res_valid |-> init_done)
        else $error("init_done dropped");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(data_pins))
        else $error("stalled result changed");

endmodule

bind char_lcd_nibble_sequencer_core clcd_checker u_clcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .data_pins (res.data_pins),
    .enable    (res.enable),
    .busy_res  (res.busy_res),
    .init_done (res.init_done),
    .accepted  (res.accepted)
);

// ----- bench/char_lcd_nibble_sequencer_core_tb.sv -----
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core_tb;
    import clcd_pkg::*;

    typedef enum logic [2:0] {
        SEQ_POWER,
        SEQ_HIGH,
        SEQ_GAP,
        SEQ_LOW,
        SEQ_POST,
        SEQ_IDLE
    } seq_phase_t;

    typedef struct packed {
        lcd_byte_t data_pins;
        logic      select_data;
        logic      read_not_write;
        logic      enable;
        logic      busy;
        logic      init_done;
        logic      accepted;
    } pin_levels_t;

    localparam opcode_t     OP_SPARE_FIRST = OP_CLEAR + 3'd1;
    localparam opcode_t     OP_SPARE_LAST  = '1;
    localparam cfg_index_t  CFG_SPARE_LAST = '1;
    localparam tick_count_t WAIT_MAX       = '1;
    // longest wait that is actually run out, keeps the item count down
    localparam tick_count_t WAIT_LONG      = 16'd40;
    // power-on bytes, first one in the low bits
    localparam logic [39:0] INIT_BYTES     = {8'h01, 8'h06, 8'h0C, 8'h28, 8'h02};
    localparam logic [27:0] ROW_START      = {7'h50, 7'h10, 7'h40, 7'h00};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    cfg_index_t  cfg_index;
    tick_count_t cfg_data;

    clcd_req_if req_if();
    clcd_res_if res_if();

    char_lcd_nibble_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .res       (res_if)
    );

    // model of the panel sequencer
    logic        cfg_upper       = 1'b1;
    tick_count_t cfg_power_wait  = POWER_WAIT_RST;
    tick_count_t cfg_enable_wait = ENABLE_WAIT_RST;
    tick_count_t cfg_cmd_wait    = CMD_WAIT_RST;
    tick_count_t cfg_clear_wait  = CLEAR_WAIT_RST;
    seq_phase_t  seq_phase       = SEQ_POWER;
    logic [2:0]  init_idx        = '0;
    tick_count_t wait_cnt        = '0;
    lcd_byte_t   cur_byte        = '0;
    logic        cur_select      = 1'b0;
    tick_count_t cur_post_wait   = '0;
    logic        init_finished   = 1'b0;

    pin_levels_t pin_levels_q[$];

    int src_gap_pct    = 0;
    int sink_gap_pct   = 0;
    int stall_request  = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int ticks_sent     = 0;
    int requests_taken = 0;
    int results_seen   = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void load_byte(input lcd_byte_t b, input logic sel,
                                      input tick_count_t after);
        cur_byte      = b;
        cur_select    = sel;
        cur_post_wait = after;
        wait_cnt      = '0;
        seq_phase     = SEQ_HIGH;
    endfunction

    function automatic pin_levels_t next_pin_levels(input opcode_t op, input lcd_byte_t bv,
                                                    input logic [1:0] row,
                                                    input logic [5:0] col);
        pin_levels_t lv;
        logic [3:0]  nib;
        logic [6:0]  addr;
        lv  = '0;
        nib = '0;
        if (op >= OP_CMD && op <= OP_CLEAR && seq_phase == SEQ_IDLE && init_finished)
        begin
            lv.accepted = 1'b1;
            case (op)
                OP_CMD:    load_byte(bv, 1'b0, cfg_cmd_wait);
                OP_DATA:   load_byte(bv, 1'b1, cfg_cmd_wait);
                OP_CURSOR:
                begin
                    // 7-bit sum wraps the address at 128
                    addr = ROW_START[row * 7 +: 7] + {1'b0, col};
                    load_byte(DDRAM_SET | {1'b0, addr}, 1'b0, cfg_cmd_wait);
                end
                default:   load_byte(LCD_CLEAR, 1'b0, cfg_clear_wait);
            endcase
        end
        else
        begin
            case (seq_phase)
                SEQ_POWER:
                    if (wait_cnt >= cfg_power_wait)
                    begin
                        init_idx = '0;
                        load_byte(INIT_BYTES[7:0], 1'b0, cfg_cmd_wait);
                    end
                    else
                        wait_cnt = wait_cnt + 1'b1;
                SEQ_HIGH:
                    if (wait_cnt >= cfg_enable_wait)
                    begin
                        seq_phase = SEQ_GAP;
                        wait_cnt  = '0;
                    end
                    else
                        wait_cnt = wait_cnt + 1'b1;
                SEQ_GAP:
                begin
                    seq_phase = SEQ_LOW;
                    wait_cnt  = '0;
                end
                SEQ_LOW:
                    if (wait_cnt >= cfg_enable_wait)
                    begin
                        seq_phase = SEQ_POST;
                        wait_cnt  = '0;
                    end
                    else
                        wait_cnt = wait_cnt + 1'b1;
                SEQ_POST:
                    if (wait_cnt >= cur_post_wait)
                    begin
                        if (!init_finished)
                            init_idx = init_idx + 3'd1;
                        if (!init_finished && init_idx < INIT_COUNT)
                            load_byte(INIT_BYTES[init_idx * 8 +: 8], 1'b0,
                                      (init_idx == INIT_COUNT - 3'd1) ? cfg_clear_wait
                                                                      : cfg_cmd_wait);
                        else
                        begin
                            init_finished = 1'b1;
                            seq_phase     = SEQ_IDLE;
                            wait_cnt      = '0;
                        end
                    end
                    else
                        wait_cnt = wait_cnt + 1'b1;
                default: seq_phase = SEQ_IDLE;
            endcase
        end

        if (seq_phase == SEQ_HIGH || seq_phase == SEQ_GAP)
            nib = cur_byte[7:4];
        else if (seq_phase == SEQ_LOW)
            nib = cur_byte[3:0];
        lv.enable         = (seq_phase == SEQ_HIGH || seq_phase == SEQ_LOW);
        lv.data_pins      = cfg_upper ? {nib, 4'h0} : {4'h0, nib};
        lv.select_data    = cur_select;
        lv.read_not_write = 1'b0;
        lv.busy           = (seq_phase != SEQ_IDLE);
        lv.init_done      = init_finished;
        return lv;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // valid stays high from one request to the next unless a gap is drawn
    task automatic send_item(input opcode_t op, input lcd_byte_t bv, input logic [1:0] row,
                             input logic [5:0] col);
        pin_levels_t lv;
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.byte_value <= bv;
        req_if.row        <= row;
        req_if.column     <= col;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        lv = next_pin_levels(op, bv, row, col);
        pin_levels_q.push_back(lv);
        ticks_sent++;
        if (lv.accepted)
            requests_taken++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pin_levels_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic tick_until_idle();
        while (seq_phase != SEQ_IDLE)
            send_item(OP_TICK, lcd_byte_t'($urandom_range(255)), 2'($urandom_range(3)),
                      6'($urandom_range(63)));
    endtask

    // after power-on setup, registers change only with the panel idle, results all in
    task automatic settle_idle();
        tick_until_idle();
        stop_sending();
        wait_drained();
    endtask

    task automatic write_reg(input cfg_index_t idx, input tick_count_t value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_NIBBLE_UPPER: cfg_upper       = value[0];
            CFG_POWER_WAIT:   cfg_power_wait  = value;
            CFG_ENABLE_WAIT:  cfg_enable_wait = value;
            CFG_CMD_WAIT:     cfg_cmd_wait    = value;
            CFG_CLEAR_WAIT:   cfg_clear_wait  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one request on an idle panel, a refused request right behind it, then run it out
    task automatic directed_byte(input opcode_t op, input lcd_byte_t bv,
                                 input logic [1:0] row, input logic [5:0] col);
        send_item(op, bv, row, col);
        send_item(opcode_t'($urandom_range(OP_CMD, OP_CLEAR)), 8'hFF, 2'd3, 6'd63);
        tick_until_idle();
    endtask

    task automatic test_power_on_init();
        write_reg(CFG_NIBBLE_UPPER, 16'd1);
        write_reg(CFG_POWER_WAIT, 16'd5);
        write_reg(CFG_ENABLE_WAIT, 16'd1);
        write_reg(CFG_CMD_WAIT, 16'd2);
        write_reg(CFG_CLEAR_WAIT, 16'd3);
        for (int i = CFG_CLEAR_WAIT + 1; i <= CFG_SPARE_LAST; i++)
            write_reg(cfg_index_t'(i), WAIT_MAX);
        // every request before init completes must be refused
        for (int i = OP_CMD; i <= OP_SPARE_LAST; i++)
            send_item(opcode_t'(i), 8'hA5, 2'd1, 6'd21);
        settle_idle();
    endtask

    task automatic test_directed_requests();
        directed_byte(OP_CMD, 8'h00, 2'd0, 6'd0);
        directed_byte(OP_CMD, 8'hFF, 2'd3, 6'd63);
        directed_byte(OP_DATA, 8'h00, 2'd0, 6'd0);
        directed_byte(OP_DATA, 8'hFF, 2'd0, 6'd0);
        directed_byte(OP_CURSOR, 8'h00, 2'd0, 6'd0);
        settle_idle();
        write_reg(CFG_NIBBLE_UPPER, 16'd0);
        directed_byte(OP_DATA, 8'h5A, 2'd2, 6'd42);
        directed_byte(OP_CURSOR, 8'hFF, 2'd1, 6'd63);
        directed_byte(OP_CURSOR, 8'h00, 2'd2, 6'd0);
        directed_byte(OP_CURSOR, 8'h00, 2'd3, 6'd63);
        directed_byte(OP_CLEAR, 8'h3C, 2'd0, 6'd0);
        // spare opcodes on an idle panel behave as ticks
        for (int i = OP_SPARE_FIRST; i <= OP_SPARE_LAST; i++)
            send_item(opcode_t'(i), 8'hC3, 2'd2, 6'd17);
        settle_idle();
    endtask

    task automatic test_wait_extremes();
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        write_reg(CFG_POWER_WAIT, WAIT_MAX);
        write_reg(CFG_ENABLE_WAIT, WAIT_LONG);
        write_reg(CFG_CMD_WAIT, WAIT_LONG);
        write_reg(CFG_CLEAR_WAIT, WAIT_LONG);
        directed_byte(OP_DATA, 8'hFF, 2'd0, 6'd0);
        settle_idle();
        write_reg(CFG_ENABLE_WAIT, 16'd0);
        write_reg(CFG_POWER_WAIT, 16'd0);
        directed_byte(OP_CLEAR, 8'h00, 2'd0, 6'd0);
        settle_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int sink_pct, input bit zero_waits);
        opcode_t op;
        int      r;
        settle_idle();
        src_gap_pct  = src_pct;
        sink_gap_pct = sink_pct;
        write_reg(CFG_NIBBLE_UPPER, tick_count_t'($urandom_range(1)));
        if (zero_waits)
        begin
            write_reg(CFG_ENABLE_WAIT, 16'd0);
            write_reg(CFG_CMD_WAIT, 16'd0);
            write_reg(CFG_CLEAR_WAIT, 16'd0);
        end
        else
        begin
            write_reg(CFG_ENABLE_WAIT, tick_count_t'($urandom_range(3)));
            write_reg(CFG_CMD_WAIT, tick_count_t'($urandom_range(6)));
            write_reg(CFG_CLEAR_WAIT, tick_count_t'($urandom_range(10)));
        end
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 150 == 149)
            begin
                stop_sending();
                wait_drained();
            end
            // mostly a request when the panel can take it, mostly ticks otherwise
            r = $urandom_range(99);
            if (seq_phase == SEQ_IDLE && r < 85)
                op = opcode_t'($urandom_range(OP_CMD, OP_CLEAR));
            else if (r < 60)
                op = OP_TICK;
            else if (r < 88)
                op = opcode_t'($urandom_range(OP_CMD, OP_CLEAR));
            else
                op = opcode_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_item(op, lcd_byte_t'($urandom_range(255)), 2'($urandom_range(3)),
                      6'($urandom_range(63)));
        end
        settle_idle();
    endtask

    task automatic test_backpressure();
        src_gap_pct   = 0;
        sink_gap_pct  = 0;
        stall_request = 200;
        for (int i = 0; i < 60; i++)
            send_item(opcode_t'($urandom_range(OP_TICK, OP_SPARE_LAST)),
                      lcd_byte_t'($urandom_range(255)), 2'($urandom_range(3)),
                      6'($urandom_range(63)));
        settle_idle();
    endtask

    always @(negedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= sink_gap_pct);
    end

    always @(posedge clk)
    begin
        pin_levels_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pin_levels_q.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pin_levels_q.pop_front();
                if (res_if.data_pins !== want.data_pins)
                    report_mismatch($sformatf("data_pins %h, want %h",
                                              res_if.data_pins, want.data_pins));
                if (res_if.select_data !== want.select_data)
                    report_mismatch($sformatf("select_data %b, want %b",
                                              res_if.select_data, want.select_data));
                if (res_if.read_not_write !== want.read_not_write)
                    report_mismatch($sformatf("read_not_write %b, want %b",
                                              res_if.read_not_write, want.read_not_write));
                if (res_if.enable !== want.enable)
                    report_mismatch($sformatf("enable %b, want %b",
                                              res_if.enable, want.enable));
                if (res_if.busy_res !== want.busy)
                    report_mismatch($sformatf("busy_res %b, want %b",
                                              res_if.busy_res, want.busy));
                if (res_if.init_done !== want.init_done)
                    report_mismatch($sformatf("init_done %b, want %b",
                                              res_if.init_done, want.init_done));
                if (res_if.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              res_if.accepted, want.accepted));
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_NIBBLE_UPPER;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_TICK;
        req_if.byte_value = '0;
        req_if.row        = '0;
        req_if.column     = '0;
        res_if.ready      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_init();
        test_directed_requests();
        test_wait_extremes();
        test_random_traffic(470, 24, 68, 1'b0);
        test_random_traffic(470, 68, 24, 1'b1);
        test_random_traffic(470, 0, 0, 1'b0);
        test_backpressure();

        stop_sending();
        wait_drained();
        repeat (20) @(posedge clk);
        $display("Covered power-on init, all request kinds, waits from 0 to %0d ticks,",
                 WAIT_LONG);
        $display("  %0d ticks sent, %0d requests taken, %0d results checked, %0d mismatches",
                 ticks_sent, requests_taken, results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results outstanding", pin_levels_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
